>>> hdl/qdd_pkg.sv
// Package of types and constants shared by the quadrature detent decoder modules.
package qdd_pkg;

    // Width of every result field on the response channel.
    localparam int OUT_WIDTH = 16;

    // Number of channels that have phase inputs on the request.
    localparam int PHASE_CHANNELS = 3;

    // Operation codes carried in the request.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Direction of the last single step.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

    // Phase difference between the pins and the fine count, modulo four.
    localparam logic [1:0] STEP_HOLD = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_JUMP = 2'd2;
    localparam logic [1:0] STEP_DOWN = 2'd3;

    // Request transaction.
    typedef struct packed {
        logic       op;
        logic       phase_a_0;
        logic       phase_b_0;
        logic       phase_a_1;
        logic       phase_b_1;
        logic       phase_a_2;
        logic       phase_b_2;
        logic [1:0] channel;
    } qdd_req_t;

    // Response transaction.
    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] detent_0;
        logic signed [OUT_WIDTH-1:0] detent_1;
        logic signed [OUT_WIDTH-1:0] detent_2;
        logic signed [OUT_WIDTH-1:0] change;
    } qdd_rsp_t;

    // Control from the top level to one lane.
    typedef struct packed {
        logic sample;
        logic read;
        logic a;
        logic b;
    } qdd_lane_ctl_t;

    // What one lane reports for the current transaction.
    typedef struct packed {
        logic [OUT_WIDTH-1:0] detent;
        logic [OUT_WIDTH-1:0] change;
    } qdd_lane_res_t;

endpackage

>>> hdl/qdd_lane.sv
// One decoder lane: fine count, detent count, direction and read baseline of one channel.
module qdd_lane
    import qdd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  qdd_lane_ctl_t ctl,
    output qdd_lane_res_t res
);

    localparam int FINE_WIDTH = COUNT_WIDTH + 2;
    localparam int CMP_WIDTH  = COUNT_WIDTH + 3;

    logic [FINE_WIDTH-1:0]  fine_reg,   fine_next;
    logic [COUNT_WIDTH-1:0] detent_reg, detent_next;
    logic [1:0]             dir_reg,    dir_next;
    logic [COUNT_WIDTH-1:0] base_reg,   base_next;

    logic [1:0]                   phase_idx;
    logic [1:0]                   step;
    logic [FINE_WIDTH-1:0]        fine_moved;
    logic [1:0]                   dir_moved;
    logic [COUNT_WIDTH-1:0]       detent_moved;
    logic signed [CMP_WIDTH-1:0]  fine_ext;
    logic signed [CMP_WIDTH-1:0]  up_limit;
    logic signed [FINE_WIDTH-1:0] down_limit;
    logic [COUNT_WIDTH-1:0]       change_raw;
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] detent_wide;
    logic [COUNT_WIDTH+OUT_WIDTH-1:0] change_wide;

    // Map the Gray-coded pins to a phase index and compare it with the fine count.
    assign phase_idx = {ctl.b, ~(ctl.a ^ ctl.b)};
    assign step      = phase_idx - fine_reg[1:0];

    // Move the fine count by the step; a double step follows the last direction.
    always_comb
    begin
        fine_moved = fine_reg;
        dir_moved  = dir_reg;
        unique case (step)
            STEP_HOLD:
            begin
                fine_moved = fine_reg;
            end
            STEP_UP:
            begin
                fine_moved = fine_reg + FINE_WIDTH'(1);
                dir_moved  = DIR_UP;
            end
            STEP_DOWN:
            begin
                fine_moved = fine_reg - FINE_WIDTH'(1);
                dir_moved  = DIR_DOWN;
            end
            STEP_JUMP:
            begin
                if (dir_reg == DIR_UP)
                begin
                    fine_moved = fine_reg + FINE_WIDTH'(2);
                end
                else if (dir_reg == DIR_DOWN)
                begin
                    fine_moved = fine_reg - FINE_WIDTH'(2);
                end
            end
            default:
            begin
                fine_moved = fine_reg;
            end
        endcase
    end

    // Detent hysteresis: the thresholds are exact; the upper one is one bit wider than the fine count.
    assign fine_ext   = $signed({fine_moved[FINE_WIDTH-1], fine_moved});
    assign up_limit   = $signed({detent_reg[COUNT_WIDTH-1], detent_reg, 2'b00})
                        + CMP_WIDTH'(6);
    assign down_limit = $signed({detent_reg, 2'b00});

    always_comb
    begin
        detent_moved = detent_reg;
        if (step != STEP_HOLD)
        begin
            if (dir_moved == DIR_UP && fine_ext > up_limit)
            begin
                detent_moved = detent_reg + COUNT_WIDTH'(1);
            end
            else if (dir_moved == DIR_DOWN && $signed(fine_moved) < down_limit)
            begin
                detent_moved = detent_reg - COUNT_WIDTH'(1);
            end
        end
    end

    // Commit a sample or a read; otherwise the state holds.
    always_comb
    begin
        fine_next   = ctl.sample ? fine_moved   : fine_reg;
        dir_next    = ctl.sample ? dir_moved    : dir_reg;
        detent_next = ctl.sample ? detent_moved : detent_reg;
        base_next   = ctl.read   ? detent_reg   : base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_reg   <= FINE_WIDTH'(3);
            detent_reg <= '0;
            dir_reg    <= DIR_NONE;
            base_reg   <= '0;
        end
        else
        begin
            fine_reg   <= fine_next;
            detent_reg <= detent_next;
            dir_reg    <= dir_next;
            base_reg   <= base_next;
        end
    end

    // Results are taken modulo the output width, zero-extended where the count is narrower.
    assign change_raw  = detent_reg - base_reg;
    assign detent_wide = {{OUT_WIDTH{1'b0}}, detent_next};
    assign change_wide = {{OUT_WIDTH{1'b0}}, change_raw};
    assign res.detent  = detent_wide[OUT_WIDTH-1:0];
    assign res.change  = change_wide[OUT_WIDTH-1:0];

endmodule

>>> hdl/qdd_merge.sv
// Merging stage: gathers the lane results into one response transaction.
module qdd_merge
    import qdd_pkg::*;
#(
    parameter int LANES = 3
)
(
    input  qdd_req_t      req,
    input  qdd_lane_res_t lane_res [LANES],
    output qdd_rsp_t      rsp
);

    logic [OUT_WIDTH-1:0] detent_sel [PHASE_CHANNELS];
    logic [OUT_WIDTH-1:0] change_sel;

    // Channels without a lane read as zero.
    always_comb
    begin
        for (int k = 0; k < PHASE_CHANNELS; k++)
        begin
            detent_sel[k] = '0;
        end
        for (int k = 0; k < LANES; k++)
        begin
            detent_sel[k] = lane_res[k].detent;
        end
    end

    // Only a read of an existing lane reports a change.
    always_comb
    begin
        change_sel = '0;
        if (req.op == OP_READ)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (req.channel == 2'(k))
                begin
                    change_sel = lane_res[k].change;
                end
            end
        end
    end

    assign rsp.detent_0 = $signed(detent_sel[0]);
    assign rsp.detent_1 = $signed(detent_sel[1]);
    assign rsp.detent_2 = $signed(detent_sel[2]);
    assign rsp.change   = $signed(change_sel);

endmodule

>>> hdl/qdd_out_buf.sv
// Output register with a skid stage between the decoder and the response channel.
module qdd_out_buf
    import qdd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  qdd_rsp_t in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output qdd_rsp_t out_data
);

    logic     main_valid_reg, main_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    qdd_rsp_t main_reg,       main_next;
    qdd_rsp_t skid_reg,       skid_next;
    logic     take_in;
    logic     main_free;

    assign in_stall  = skid_valid_reg;
    assign take_in   = in_valid && !skid_valid_reg;
    assign main_free = !main_valid_reg || !out_stall;

    // The skid entry drains first; a new transaction parks there only while the output is held.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = take_in;
            end
        end
        else if (take_in)
        begin
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

>>> hdl/quadrature_detent_decoder_unit.sv
// Top level of the three-channel quadrature decoder with detent hysteresis.
//
//  Channel   Signals                        Moves
//  request   req_valid, req_stall, req_data   one sample or read transaction
//  response  rsp_valid, rsp_stall, rsp_data   detent counts and read change
//
// One transaction is accepted per cycle while req_stall is low. A sample
// updates all lanes in the accept cycle: adds and two compares per lane. Reset
// sets each fine count to three and clears all else but buffered data at once.
// A stalled response is held; one further transaction is taken into the skid
// stage, after which req_stall rises until the response is taken.
module quadrature_detent_decoder_unit
    import qdd_pkg::*;
#(
    parameter int CHANNELS    = 3,
    parameter int COUNT_WIDTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  qdd_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output qdd_rsp_t rsp_data
);

    // Channels past the phase inputs never move, so they need no lane.
    localparam int LANES = (CHANNELS < PHASE_CHANNELS) ? CHANNELS : PHASE_CHANNELS;

    logic          accept;
    logic          buf_stall;
    logic [PHASE_CHANNELS-1:0] pin_a;
    logic [PHASE_CHANNELS-1:0] pin_b;
    qdd_lane_ctl_t lane_ctl [LANES];
    qdd_lane_res_t lane_res [LANES];
    qdd_rsp_t      merged;

    assign accept    = req_valid && !buf_stall;
    assign req_stall = buf_stall;

    assign pin_a = {req_data.phase_a_2, req_data.phase_a_1, req_data.phase_a_0};
    assign pin_b = {req_data.phase_b_2, req_data.phase_b_1, req_data.phase_b_0};

    // One lane per channel with phase inputs.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        assign lane_ctl[k].sample = accept && (req_data.op == OP_SAMPLE);
        assign lane_ctl[k].read   = accept && (req_data.op == OP_READ)
                                    && (req_data.channel == 2'(k));
        assign lane_ctl[k].a      = pin_a[k];
        assign lane_ctl[k].b      = pin_b[k];

        qdd_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (lane_ctl[k]),
            .res   (lane_res[k])
        );
    end

    // Combine the lane results into the response.
    qdd_merge #(
        .LANES (LANES)
    ) u_merge (
        .req      (req_data),
        .lane_res (lane_res),
        .rsp      (merged)
    );

    // Register the response and decouple the two channels.
    qdd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (buf_stall),
        .in_data   (merged),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data)
    );

endmodule

>>> tb/quadrature_detent_decoder_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the three-channel quadrature detent decoder.
module quadrature_detent_decoder_unit_tb
    import qdd_pkg::*;
();

    localparam int LANES        = 3;
    localparam int COUNT_W      = 16;
    localparam int FINE_W       = COUNT_W + 2;
    localparam int RESET_CYCLES = 11;
    localparam int MAX_WAIT     = 10;
    localparam int RANDOM_ITEMS = 420;
    localparam int SETTLE       = 8;
    // Jump counts of the full-rate sweeps; the second one carries lanes 0 and 1 back past their start.
    localparam int UP_SWEEP     = 24;
    localparam int CROSS_SWEEP  = 48;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    qdd_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    qdd_rsp_t rsp_data;

    // Predicted state of every lane.
    logic signed [FINE_W-1:0]  fine_pos   [LANES];
    logic signed [COUNT_W-1:0] detent_pos [LANES];
    logic [1:0]                last_dir   [LANES];
    logic [COUNT_W-1:0]        read_mark  [LANES];

    // Detent counts owed by the block, oldest first.
    qdd_rsp_t owed_counts [$];
    int       fail_count = 0;
    bit       pace_on    = 1'b1;
    int       stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    quadrature_detent_decoder_unit #(
        .CHANNELS    (LANES),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // State of the lanes straight after reset.
    function automatic void reset_lanes();
        for (int k = 0; k < LANES; k++)
        begin
            fine_pos[k]   = 3;
            detent_pos[k] = '0;
            last_dir[k]   = DIR_NONE;
            read_mark[k]  = '0;
        end
    endfunction

    // One lane's response to a pin sample: fine step, then the detent hysteresis.
    function automatic void advance_lane(int k, logic a, logic b);
        logic [1:0] idx;
        logic [1:0] step;
        int         f;
        int         t;
        idx  = {b, ~(a ^ b)};
        step = idx - fine_pos[k][1:0];
        if (step == STEP_HOLD)
            return;
        case (step)
            STEP_UP:
            begin
                fine_pos[k] = fine_pos[k] + 1;
                last_dir[k] = DIR_UP;
            end
            STEP_DOWN:
            begin
                fine_pos[k] = fine_pos[k] - 1;
                last_dir[k] = DIR_DOWN;
            end
            default:
            begin
                // A two-step jump follows the last known direction, if any.
                if (last_dir[k] == DIR_UP)
                    fine_pos[k] = fine_pos[k] + 2;
                else if (last_dir[k] == DIR_DOWN)
                    fine_pos[k] = fine_pos[k] - 2;
            end
        endcase
        // The thresholds are compared at full precision, without wrapping.
        f = fine_pos[k];
        t = detent_pos[k];
        t = t * 4;
        if (last_dir[k] == DIR_UP && f > t + 6)
            detent_pos[k] = detent_pos[k] + 1;
        else if (last_dir[k] == DIR_DOWN && f < t)
            detent_pos[k] = detent_pos[k] - 1;
    endfunction

    // Counts that one accepted transaction produces; updates the predicted state.
    function automatic qdd_rsp_t decode_step(qdd_req_t item);
        qdd_rsp_t res;
        res.change = '0;
        if (item.op == OP_SAMPLE)
        begin
            advance_lane(0, item.phase_a_0, item.phase_b_0);
            advance_lane(1, item.phase_a_1, item.phase_b_1);
            advance_lane(2, item.phase_a_2, item.phase_b_2);
        end
        else if (item.channel < LANES)
        begin
            res.change = detent_pos[item.channel] - read_mark[item.channel];
            read_mark[item.channel] = detent_pos[item.channel];
        end
        res.detent_0 = detent_pos[0];
        res.detent_1 = detent_pos[1];
        res.detent_2 = detent_pos[2];
        return res;
    endfunction

    // Pin levels {a, b} that encode the given phase index.
    function automatic logic [1:0] pins_at(logic [1:0] idx);
        return {~idx[0] ^ idx[1], idx[1]};
    endfunction

    // Sample that moves each lane by the given step relative to its predicted position.
    function automatic qdd_req_t sample_item(logic [1:0] d0, logic [1:0] d1, logic [1:0] d2);
        qdd_req_t item;
        item.op = OP_SAMPLE;
        {item.phase_a_0, item.phase_b_0} = pins_at(2'(fine_pos[0][1:0] + d0));
        {item.phase_a_1, item.phase_b_1} = pins_at(2'(fine_pos[1][1:0] + d1));
        {item.phase_a_2, item.phase_b_2} = pins_at(2'(fine_pos[2][1:0] + d2));
        item.channel = 2'($urandom_range(0, 3));
        return item;
    endfunction

    // Read of one channel; the pin fields carry random levels that must be ignored.
    function automatic qdd_req_t read_item(logic [1:0] ch);
        qdd_req_t item;
        item = qdd_req_t'({OP_READ, 8'($urandom)});
        item.channel = ch;
        return item;
    endfunction

    // Offers one transaction, after a random gap while pacing is on, and records its counts once accepted.
    task automatic send_req(input qdd_req_t item);
        int gap;
        gap = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall !== 1'b0)
            @(posedge clk);
        owed_counts.push_back(decode_step(item));
    endtask

    // Holds the request side idle until every owed response has been taken.
    task automatic wait_for_counts();
        req_valid <= 1'b0;
        @(posedge clk);
        while (owed_counts.size() != 0)
            @(posedge clk);
    endtask

    // Reads straight after reset, the out-of-range channel and jumps with no direction.
    task automatic test_after_reset();
        for (int ch = 0; ch < 4; ch++)
            send_req(read_item(2'(ch)));
        send_req(sample_item(STEP_HOLD, STEP_HOLD, STEP_HOLD));
        send_req(sample_item(STEP_JUMP, STEP_JUMP, STEP_JUMP));
        wait_for_counts();
    endtask

    // Detent steps in both directions, hysteresis on the way back and directed jumps.
    task automatic test_detent_thresholds();
        repeat (5) send_req(sample_item(STEP_UP, STEP_DOWN, STEP_UP));
        repeat (5) send_req(sample_item(STEP_JUMP, STEP_JUMP, STEP_DOWN));
        for (int ch = 0; ch < 4; ch++)
            send_req(read_item(2'(ch)));
        wait_for_counts();
    endtask

    // Full-rate jump sweeps that carry the first two detent counts away from zero and back past
    // it in the other direction, with reads in between.
    task automatic test_full_rate_sweep();
        pace_on = 1'b0;
        send_req(sample_item(STEP_UP, STEP_DOWN, STEP_HOLD));
        repeat (UP_SWEEP)
            send_req(sample_item(STEP_JUMP, STEP_JUMP, 2'($urandom_range(0, 3))));
        send_req(read_item(2'd0));
        send_req(read_item(2'd1));
        send_req(sample_item(STEP_DOWN, STEP_UP, STEP_HOLD));
        repeat (CROSS_SWEEP)
            send_req(sample_item(STEP_JUMP, STEP_JUMP, 2'($urandom_range(0, 3))));
        for (int ch = 0; ch < 4; ch++)
            send_req(read_item(2'(ch)));
        wait_for_counts();
        pace_on = 1'b1;
    endtask

    // Mostly clean quadrature motion with a drift per lane, plus reads and pin noise.
    task automatic test_random_traffic();
        logic [1:0] drift [LANES];
        logic [1:0] moves [LANES];
        int         pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                pace_on = ($urandom_range(0, 3) != 0);
                for (int k = 0; k < LANES; k++)
                    drift[k] = $urandom_range(0, 1) ? STEP_UP : STEP_DOWN;
            end
            // Let the pipeline empty once in the middle of the traffic.
            if (n == RANDOM_ITEMS / 2)
                wait_for_counts();
            pick = $urandom_range(0, 99);
            if (pick < 15)
                send_req(read_item(2'($urandom_range(0, 3))));
            else if (pick < 27)
                send_req(qdd_req_t'({OP_SAMPLE, 8'($urandom)}));
            else
            begin
                for (int k = 0; k < LANES; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        moves[k] = drift[k];
                    else if (pick < 75)
                        moves[k] = STEP_HOLD;
                    else if (pick < 90)
                        moves[k] = (drift[k] == STEP_UP) ? STEP_DOWN : STEP_UP;
                    else
                        moves[k] = STEP_JUMP;
                end
                send_req(sample_item(moves[0], moves[1], moves[2]));
            end
        end
        wait_for_counts();
        pace_on = 1'b1;
    endtask

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, $signed(want), $signed(got));
            fail_count++;
        end
    endfunction

    // Compares each accepted response with the oldest owed counts.
    always @(posedge clk)
    begin : check_rsp
        qdd_rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_stall == 1'b0)
        begin
            if (owed_counts.size() == 0)
            begin
                $error("response transaction with nothing outstanding");
                fail_count++;
            end
            else
            begin
                want = owed_counts.pop_front();
                check_field("detent_0", want.detent_0, rsp_data.detent_0);
                check_field("detent_1", want.detent_1, rsp_data.detent_1);
                check_field("detent_2", want.detent_2, rsp_data.detent_2);
                check_field("change", want.change, rsp_data.change);
            end
        end
    end

    // Receiver back-pressure: a fresh random wait after every response taken.
    always @(posedge clk)
    begin
        if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            stall_left = pace_on ? $urandom_range(0, MAX_WAIT) : 0;
        else if (stall_left > 0)
            stall_left--;
        rsp_stall <= (stall_left != 0);
    end

    initial
    begin
        reset_lanes();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_detent_thresholds();
        test_random_traffic();
        test_full_rate_sweep();
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
